>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> src/etps_pkg.sv
// ----------------------------------------------------------------------------
// ESC throttle pulse sequencer package
// Payload types, command codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package etps_pkg;

    localparam int WIDTH_W   = 12;
    localparam int HOLD_W    = 8;
    localparam int SPEED_W   = 8;
    localparam int X_W       = 7;
    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE   = 3'd5;

    localparam logic [WIDTH_W-1:0] RST_NEUTRAL = 12'd1500;
    localparam logic [WIDTH_W-1:0] RST_FWD_MIN = 12'd1500;
    localparam logic [WIDTH_W-1:0] RST_FWD_MAX = 12'd2000;
    localparam logic [WIDTH_W-1:0] RST_REV_MIN = 12'd1500;
    localparam logic [WIDTH_W-1:0] RST_REV_MAX = 12'd1000;
    localparam logic [WIDTH_W-1:0] RST_BRAKE   = 12'd1000;

    localparam logic [WIDTH_W-1:0] ARM_HIGH = 12'd1500;
    localparam logic [WIDTH_W-1:0] ARM_LOW  = 12'd1400;

    localparam logic [HOLD_W-1:0] HOLD_NONE      = 8'd0;
    localparam logic [HOLD_W-1:0] ARM_HOLD_FIRST = 8'd125;
    localparam logic [HOLD_W-1:0] ARM_HOLD_NEXT  = 8'd25;
    localparam logic [HOLD_W-1:0] FWD_REV_HOLD   = 8'd200;

    localparam logic signed [SPEED_W-1:0] SPEED_ZERO   = 8'sd0;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX    = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN    = -8'sd100;
    localparam logic signed [SPEED_W-1:0] BRAKED_SPEED = 8'sd123;

    localparam logic [SPEED_W-1:0] FWD_OFFSET = 8'd1;
    localparam logic [SPEED_W-1:0] REV_OFFSET = 8'd100;

    // x / 99 as (x * RECIP) >> RECIP_SHIFT, exact for x below 2^19
    localparam int                 MAG_W       = X_W + WIDTH_W;
    localparam int                 RECIP_W     = 20;
    localparam int                 RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP       = 20'd677868;

    localparam logic [1:0] STEP_HIGH0  = 2'd0;
    localparam logic [1:0] STEP_LOW    = 2'd1;
    localparam logic [1:0] STEP_HIGH1  = 2'd2;
    localparam logic [1:0] STEP_MAPPED = 2'd3;

    typedef enum logic [2:0] {
        K_BRAKE,
        K_NEUTRAL,
        K_FWD,
        K_REV,
        K_ARM
    } t_kind;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_MUL,
        BS_DIV,
        BS_EMIT
    } t_bstate;

    typedef struct packed {
        logic                      func;
        logic signed [SPEED_W-1:0] speed_cmd;
    } t_in;

    typedef struct packed {
        logic [WIDTH_W-1:0]        pulse_us;
        logic [HOLD_W-1:0]         hold_ms;
        logic                      last;
        logic                      in_reverse;
        logic signed [SPEED_W-1:0] speed_now;
    } t_res;

    typedef struct packed {
        t_kind                     kind;
        logic [X_W-1:0]            x;
        logic                      hold200;
        logic                      in_reverse;
        logic signed [SPEED_W-1:0] speed_now;
    } t_cmd;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [WIDTH_W-1:0]   data;
    } t_cfg_wr;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

endpackage

`default_nettype wire

>>> src/etps_fifo.sv
// ----------------------------------------------------------------------------
// ESC throttle pulse sequencer queue
// Small first-word-fall-through queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module etps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> src/etps_front.sv
// ----------------------------------------------------------------------------
// ESC throttle pulse sequencer front end
// Classifies commands, tracks reverse mode and recorded speed.
// ----------------------------------------------------------------------------
`default_nettype none

module etps_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire etps_pkg::t_in  i_cmd,
    output logic                o_push,
    output etps_pkg::t_cmd      o_cmd
);

    import etps_pkg::*;

    logic                      r_rev, n_rev;
    logic signed [SPEED_W-1:0] r_spd, n_spd;
    logic signed [SPEED_W-1:0] spd;
    logic [SPEED_W-1:0]        fwd_x, rev_x;

    assign spd   = i_cmd.speed_cmd;
    assign fwd_x = SPEED_W'(spd) - FWD_OFFSET;
    assign rev_x = SPEED_W'(spd) + REV_OFFSET;

    always_comb begin
        n_rev            = r_rev;
        n_spd            = r_spd;
        o_push           = 1'b0;
        o_cmd.kind       = K_NEUTRAL;
        o_cmd.x          = '0;
        o_cmd.hold200    = 1'b0;
        o_cmd.in_reverse = r_rev;
        o_cmd.speed_now  = r_spd;
        if (i_accept) begin
            if (i_cmd.func) begin
                o_push          = 1'b1;
                o_cmd.kind      = K_BRAKE;
                o_cmd.speed_now = BRAKED_SPEED;
                n_spd           = BRAKED_SPEED;
            end else if (spd == SPEED_ZERO) begin
                o_push = 1'b1;
            end else if (spd > SPEED_ZERO && spd <= SPEED_MAX) begin
                o_push           = 1'b1;
                o_cmd.kind       = K_FWD;
                o_cmd.x          = fwd_x[X_W-1:0];
                o_cmd.hold200    = r_spd[SPEED_W-1];
                o_cmd.in_reverse = 1'b0;
                o_cmd.speed_now  = spd;
                n_spd            = spd;
                n_rev            = 1'b0;
            end else if (spd < SPEED_ZERO && spd >= SPEED_MIN) begin
                o_push           = 1'b1;
                o_cmd.kind       = r_rev ? K_REV : K_ARM;
                o_cmd.x          = rev_x[X_W-1:0];
                o_cmd.in_reverse = 1'b1;
                o_cmd.speed_now  = spd;
                n_spd            = spd;
                n_rev            = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= 1'b0;
            r_spd <= '0;
        end else begin
            r_rev <= n_rev;
            r_spd <= n_spd;
        end
    end

endmodule

`default_nettype wire

>>> src/etps_back.sv
// ----------------------------------------------------------------------------
// ESC throttle pulse sequencer back end
// Holds the width registers, maps speeds to widths and emits each pulse run.
// ----------------------------------------------------------------------------
`default_nettype none

module etps_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire etps_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_cmd_empty,
    output logic                   o_cmd_pop,
    input  wire etps_pkg::t_cmd    i_cmd,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output etps_pkg::t_res         o_res
);

    import etps_pkg::*;

    t_bstate                   r_state, n_state;
    logic [1:0]                r_step, n_step;
    t_cmd                      r_cmd;
    logic [WIDTH_W-1:0]        r_cfg [NUM_CFG];
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg;
    logic [WIDTH_W-1:0]        r_quo;

    logic [WIDTH_W-1:0]        y0, y1;
    logic signed [WIDTH_W:0]   diff;
    logic [WIDTH_W:0]          neg_diff;
    logic [WIDTH_W-1:0]        abs_diff;
    logic [MAG_W-1:0]          mul_prod;
    logic [MAG_W+RECIP_W-1:0]  div_prod;
    logic [WIDTH_W-1:0]        offset;
    logic [WIDTH_W-1:0]        mapped;
    logic                      res_last;

    assign y0       = (r_cmd.kind == K_FWD) ? r_cfg[CFG_FWD_MIN] : r_cfg[CFG_REV_MAX];
    assign y1       = (r_cmd.kind == K_FWD) ? r_cfg[CFG_FWD_MAX] : r_cfg[CFG_REV_MIN];
    assign diff     = $signed({1'b0, y1}) - $signed({1'b0, y0});
    assign neg_diff = -diff;
    assign abs_diff = diff[WIDTH_W] ? neg_diff[WIDTH_W-1:0] : diff[WIDTH_W-1:0];
    assign mul_prod = {{WIDTH_W{1'b0}}, r_cmd.x} * {{X_W{1'b0}}, abs_diff};
    assign div_prod = {{RECIP_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, RECIP};
    assign offset   = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign mapped   = y0 + offset;
    assign res_last = (r_cmd.kind != K_ARM) || (r_step == STEP_MAPPED);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_step    = STEP_HIGH0;
                    n_state   = BS_MUL;
                end
            end
            BS_MUL: begin
                n_state = BS_DIV;
            end
            BS_DIV: begin
                n_state = BS_EMIT;
            end
            BS_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (res_last) begin
                        n_state = BS_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.pulse_us   = mapped;
        o_res.hold_ms    = HOLD_NONE;
        o_res.last       = res_last;
        o_res.in_reverse = r_cmd.in_reverse;
        o_res.speed_now  = r_cmd.speed_now;
        case (r_cmd.kind)
            K_BRAKE: begin
                o_res.pulse_us = r_cfg[CFG_BRAKE];
            end
            K_NEUTRAL: begin
                o_res.pulse_us = r_cfg[CFG_NEUTRAL];
            end
            K_FWD: begin
                o_res.hold_ms = r_cmd.hold200 ? FWD_REV_HOLD : HOLD_NONE;
            end
            K_ARM: begin
                case (r_step)
                    STEP_HIGH0: begin
                        o_res.pulse_us = ARM_HIGH;
                    end
                    STEP_LOW: begin
                        o_res.pulse_us = ARM_LOW;
                        o_res.hold_ms  = ARM_HOLD_FIRST;
                    end
                    STEP_HIGH1: begin
                        o_res.pulse_us = ARM_HIGH;
                        o_res.hold_ms  = ARM_HOLD_NEXT;
                    end
                    default: begin
                        o_res.hold_ms = ARM_HOLD_NEXT;
                    end
                endcase
            end
            default: begin
                o_res.pulse_us = mapped;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_step  <= STEP_HIGH0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_NEUTRAL] <= RST_NEUTRAL;
            r_cfg[CFG_FWD_MIN] <= RST_FWD_MIN;
            r_cfg[CFG_FWD_MAX] <= RST_FWD_MAX;
            r_cfg[CFG_REV_MIN] <= RST_REV_MIN;
            r_cfg[CFG_REV_MAX] <= RST_REV_MAX;
            r_cfg[CFG_BRAKE]   <= RST_BRAKE;
        end else if (i_cfg.we && (i_cfg.idx < CFG_IDX_W'(NUM_CFG))) begin
            r_cfg[i_cfg.idx] <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == BS_MUL) begin
            r_mag <= mul_prod;
            r_neg <= diff[WIDTH_W];
        end
        if (r_state == BS_DIV) begin
            r_quo <= div_prod[RECIP_SHIFT +: WIDTH_W];
        end
    end

endmodule

`default_nettype wire

>>> src/esc_throttle_pulse_sequencer_top.sv
// ----------------------------------------------------------------------------
// ESC throttle pulse sequencer
// Turns speed and brake commands into servo pulse widths with hold times.
//
// Command side: an item is taken when push is high and full is low. Each
// command yields one result, four for a reverse command while not in reverse
// mode (arming run), none for a speed outside -100..100.
// Result side: while empty is low the oldest result is on o_res; pop takes it.
// Width registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// indexes beyond five are ignored.
// A taken command waits in the command queue; the back end pops it, steps
// through its multiply, divide and emit states and writes each result into
// the result queue. It handles one command at a time; a command queue of
// CMD_DEPTH items keeps taking commands meanwhile.
// When pop is held low, results collect in a RES_DEPTH queue, then the back
// end and finally full stall.
// Reset: queues empty, reverse mode off, recorded speed zero, widths back to
// their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_throttle_pulse_sequencer_top #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    input  wire etps_pkg::t_in                    i_cmd,
    output logic                                  full,
    input  wire logic                             pop,
    output logic                                  empty,
    output etps_pkg::t_res                        o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [etps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [etps_pkg::WIDTH_W-1:0]     i_cfg_data
);

    import etps_pkg::*;

`include "assert_macros.svh"

    logic       accept;
    logic       drop_cmd;
    logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_cmd       front_cmd, back_cmd;
    logic       res_push, res_full;
    t_res       back_res;
    t_cfg_wr    cfg_wr;
    logic [CMD_W-1:0] cmd_bits;
    logic [RES_W-1:0] res_bits;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign back_cmd = t_cmd'(cmd_bits);
    assign o_res    = t_res'(res_bits);
    assign drop_cmd = !i_cmd.func &&
                      ((i_cmd.speed_cmd > SPEED_MAX) || (i_cmd.speed_cmd < SPEED_MIN));

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    etps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd),
        .o_push   (cmd_push),
        .o_cmd    (front_cmd)
    );

    etps_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_bits)
    );

    etps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (back_cmd),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    etps_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_bits)
    );

    `ASSERT_NEVER(a_cmd_no_overflow, i_clk, i_rst_n, cmd_push && cmd_full)
    `ASSERT_NEVER(a_res_no_overflow, i_clk, i_rst_n, res_push && res_full)
    `ASSERT_CLK(a_brake_queued, i_clk, i_rst_n, (accept && i_cmd.func) |-> cmd_push)
    `ASSERT_CLK(a_range_dropped, i_clk, i_rst_n, (accept && drop_cmd) |-> !cmd_push)

endmodule

`default_nettype wire
